// File: hdl/smd_pkg.sv
// Package with constants, types and helpers shared by the sliding median filter.
package smd_pkg;

  // Sizing of the window ring and of one sample.
  localparam int MAX_WINDOW  = 32;
  localparam int SAMPLE_BITS = 32;
  localparam int CFG_W       = 6;
  localparam int PTR_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
  localparam int STEP_W      = $clog2(SAMPLE_BITS);

  typedef logic [PTR_W-1:0]       ptr_t;
  typedef logic [LEN_W-1:0]       len_t;
  typedef logic [STEP_W-1:0]      step_t;
  typedef logic [MAX_WINDOW-1:0]  lane_vec_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_EMIT
  } state_t;

  // Control from the sequencer to the sample lanes.
  typedef struct packed {
    logic wr_en;
    logic shift;
    ptr_t wr_ptr;
  } lane_ctl_t;

  // Control from the sequencer to the rank selector.
  typedef struct packed {
    logic load;
    logic shift;
    logic first;
  } rank_ctl_t;

  // Window length as used: zero acts as one, anything above the ring size saturates.
  function automatic len_t clamp_len(logic [CFG_W-1:0] v);
    len_t r;
    if (v == '0) begin
      r = len_t'(1);
    end else if (int'(v) > MAX_WINDOW) begin
      r = len_t'(MAX_WINDOW);
    end else begin
      r = len_t'(v);
    end
    return r;
  endfunction

endpackage

// File: hdl/smd_if.sv
// Valid/ready channel interfaces for the sample input and the median output.
interface smd_in_if;
  import smd_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface smd_out_if;
  import smd_pkg::*;
  logic    valid;
  logic    ready;
  sample_t median_value;
  logic    run_end;
  logic    trace_end;
  logic    short_trace;

  modport source (output valid, output median_value, output run_end, output trace_end,
                  output short_trace, input ready);
  modport sink   (input valid, input median_value, input run_end, input trace_end,
                  input short_trace, output ready);
endinterface

// File: hdl/sliding_median_despike.sv
// Sliding-window median despiker: a new sample that completes a window is accepted,
// then the rank is selected bit-serially (one bit of every lane per cycle), then
// one beat per result is emitted as the receiver takes them; no new sample is
// taken until the last result of that window has been issued.
// Samples that only fill the window, without ending the trace, are taken one per cycle.
// Synchronous active-low reset clears the sequencer, counters and output valid.
module sliding_median_despike
  import smd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  smd_in_if.sink           in_ch,
  smd_out_if.source        out_ch
);

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] cfg_len_r;
  len_t             act_len_r, act_len_nxt;
  len_t             cnt_r, cnt_nxt;
  ptr_t             wp_r, wp_nxt;
  step_t            step_r, step_nxt;
  len_t             left_r, left_nxt;
  logic             last_r, last_nxt;
  logic             short_r, short_nxt;
  logic             out_valid_r, out_valid_nxt;
  sample_t          out_med_r, out_med_nxt;
  logic             out_run_r, out_run_nxt;
  logic             out_tend_r, out_tend_nxt;
  logic             out_short_r, out_short_nxt;

  logic      in_ready;
  logic      accept;
  logic      out_free;
  len_t      len_now, half_now, cnt_inc, nres_now;
  logic      full;
  ptr_t      wp_inc;
  lane_vec_t win_mask;
  lane_ctl_t lane_ctl;
  rank_ctl_t rank_ctl;
  lane_vec_t msb_col;
  sample_t   median;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= CFG_W'(1);
    end else if (cfg_we) begin
      cfg_len_r <= cfg_wdata;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Window bookkeeping for the incoming beat.
  always_comb begin
    len_now  = (cnt_r == '0) ? clamp_len(cfg_len_r) : act_len_r;
    half_now = len_now >> 1;
    cnt_inc  = cnt_r + len_t'(1);
    full     = (cnt_inc >= len_now);
    wp_inc   = (wp_r == ptr_t'(MAX_WINDOW - 1)) ? '0 : wp_r + ptr_t'(1);
    nres_now = ((cnt_inc == len_now) ? (half_now + len_t'(1)) : len_t'(1))
             + (in_ch.last_sample ? (len_now - len_t'(1) - half_now) : '0);
  end

  // Lanes holding the latest len_now samples, counted back from the new one.
  always_comb begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      if ({1'b0, wp_r} >= LEN_W'(j)) begin
        win_mask[j] = (({1'b0, wp_r} - LEN_W'(j)) < len_now);
      end else begin
        win_mask[j] = (({1'b0, wp_r} + LEN_W'(MAX_WINDOW) - LEN_W'(j)) < len_now);
      end
    end
  end

  // Sequencer: next state and control.
  always_comb begin
    state_nxt     = state_r;
    act_len_nxt   = act_len_r;
    cnt_nxt       = cnt_r;
    wp_nxt        = wp_r;
    step_nxt      = step_r;
    left_nxt      = left_r;
    last_nxt      = last_r;
    short_nxt     = short_r;
    out_valid_nxt = out_valid_r;
    out_med_nxt   = out_med_r;
    out_run_nxt   = out_run_r;
    out_tend_nxt  = out_tend_r;
    out_short_nxt = out_short_r;
    lane_ctl      = '{wr_en: accept, shift: 1'b0, wr_ptr: wp_r};
    rank_ctl      = '{load: 1'b0, shift: 1'b0, first: (step_r == '0)};

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          act_len_nxt = len_now;
          wp_nxt      = wp_inc;
          cnt_nxt     = full ? len_now : cnt_inc;
          last_nxt    = in_ch.last_sample;
          if (!full) begin
            if (in_ch.last_sample) begin
              // Trace ended before a full window: one flagged result.
              short_nxt = 1'b1;
              left_nxt  = len_t'(1);
              cnt_nxt   = '0;
              wp_nxt    = '0;
              state_nxt = ST_EMIT;
            end
          end else begin
            short_nxt     = 1'b0;
            left_nxt      = nres_now;
            step_nxt      = '0;
            rank_ctl.load = 1'b1;
            state_nxt     = ST_SEL;
            if (in_ch.last_sample) begin
              cnt_nxt = '0;
              wp_nxt  = '0;
            end
          end
        end
      end

      ST_SEL: begin
        lane_ctl.shift = 1'b1;
        rank_ctl.shift = 1'b1;
        step_nxt       = step_r + step_t'(1);
        if (step_r == step_t'(SAMPLE_BITS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_med_nxt   = short_r ? '0 : median;
          out_run_nxt   = (left_r == len_t'(1));
          out_tend_nxt  = (left_r == len_t'(1)) && last_r;
          out_short_nxt = short_r;
          left_nxt      = left_r - len_t'(1);
          if (left_r == len_t'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      act_len_r   <= len_t'(1);
      cnt_r       <= '0;
      wp_r        <= '0;
      step_r      <= '0;
      left_r      <= '0;
      last_r      <= 1'b0;
      short_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      act_len_r   <= act_len_nxt;
      cnt_r       <= cnt_nxt;
      wp_r        <= wp_nxt;
      step_r      <= step_nxt;
      left_r      <= left_nxt;
      last_r      <= last_nxt;
      short_r     <= short_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    out_med_r   <= out_med_nxt;
    out_run_r   <= out_run_nxt;
    out_tend_r  <= out_tend_nxt;
    out_short_r <= out_short_nxt;
  end

  smd_lanes u_lanes (
    .clk     (clk),
    .ctl     (lane_ctl),
    .wr_data (in_ch.sample),
    .msb_col (msb_col)
  );

  smd_rank u_rank (
    .clk       (clk),
    .ctl       (rank_ctl),
    .load_mask (win_mask),
    .load_rank (half_now),
    .msb_col   (msb_col),
    .result    (median)
  );

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.median_value = out_med_r;
  assign out_ch.run_end      = out_run_r;
  assign out_ch.trace_end    = out_tend_r;
  assign out_ch.short_trace  = out_short_r;

endmodule

// File: hdl/smd_lanes.sv
// Ring of sample lanes that rotate one bit per cycle while shifting, most significant bit first.
module smd_lanes
  import smd_pkg::*;
(
  input  logic      clk,
  input  lane_ctl_t ctl,
  input  sample_t   wr_data,
  output lane_vec_t msb_col
);

  sample_t lane_r [MAX_WINDOW];

  // Write one lane on a new sample; rotate all lanes during selection.
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      if (ctl.wr_en && (ctl.wr_ptr == ptr_t'(j))) begin
        lane_r[j] <= wr_data;
      end else if (ctl.shift) begin
        lane_r[j] <= {lane_r[j][SAMPLE_BITS-2:0], lane_r[j][SAMPLE_BITS-1]};
      end
    end
  end

  // Each lane presents its current top bit.
  always_comb begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      msb_col[j] = lane_r[j][SAMPLE_BITS-1];
    end
  end

endmodule

// File: hdl/smd_rank.sv
// Bit-serial rank selector: narrows a candidate set one bit per cycle while shifting.
module smd_rank
  import smd_pkg::*;
(
  input  logic      clk,
  input  rank_ctl_t ctl,
  input  lane_vec_t load_mask,
  input  len_t      load_rank,
  input  lane_vec_t msb_col,
  output sample_t   result
);

  lane_vec_t mask_r, mask_nxt;
  len_t      rank_r, rank_nxt;
  sample_t   res_r,  res_nxt;
  lane_vec_t key_col;
  len_t      zeros;
  logic      res_bit;

  // Order key bits: the sign bit is inverted so unsigned order matches signed order.
  assign key_col = ctl.first ? ~msb_col : msb_col;

  // Count candidates whose key bit is zero, then keep the half holding the rank.
  always_comb begin
    zeros = '0;
    for (int j = 0; j < MAX_WINDOW; j++) begin
      zeros = zeros + len_t'(mask_r[j] & ~key_col[j]);
    end
    res_bit  = (rank_r >= zeros);
    mask_nxt = mask_r;
    rank_nxt = rank_r;
    res_nxt  = res_r;
    if (ctl.load) begin
      mask_nxt = load_mask;
      rank_nxt = load_rank;
    end else if (ctl.shift) begin
      if (res_bit) begin
        mask_nxt = mask_r & key_col;
        rank_nxt = rank_r - zeros;
      end else begin
        mask_nxt = mask_r & ~key_col;
      end
      res_nxt = {res_r[SAMPLE_BITS-2:0], res_bit ^ ctl.first};
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    rank_r <= rank_nxt;
    res_r  <= res_nxt;
  end

  assign result = res_r;

endmodule

// File: tb/sv/sliding_median_despike_test.sv
// Self-checking testbench for the sliding-window median despiker.
module sliding_median_despike_test;
  import smd_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 38;

  // One expected result beat.
  typedef struct packed {
    sample_t value;
    logic    run_end;
    logic    trace_end;
    logic    short_trace;
  } median_beat_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  smd_in_if  in_ch ();
  smd_out_if out_ch ();

  sliding_median_despike u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow of the filter state, advanced on every accepted input beat.
  median_beat_t     median_due[$];
  sample_t          trace_ring[MAX_WINDOW];
  int               fill_cnt = 0;
  int               ring_slot = 0;
  int               trace_len = 1;
  logic [CFG_W-1:0] len_setting = 1;

  // Traffic shaping knobs and run statistics.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int mismatches = 0;
  int samples_sent = 0;
  int beats_checked = 0;
  int traces_done = 0;
  int short_traces = 0;
  int longest_len = 1;
  int quiet_cycles = 0;
  median_beat_t due_beat;

  always #10 clk = ~clk;

  // Window length in effect for a register value: zero means one, large values saturate.
  function automatic int used_len(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_WINDOW) return MAX_WINDOW;
    return int'(v);
  endfunction

  // Random sample biased toward the range limits and toward small values that tie.
  function automatic sample_t noisy_sample();
    case ($urandom_range(9, 0))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return sample_t'($urandom_range(6, 0) - 3);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Works out the median beats that one accepted sample causes.
  function automatic void predict_medians(input sample_t s, input logic last);
    sample_t window[MAX_WINDOW];
    sample_t key;
    int      half, prior, n_res, i, j;
    if (fill_cnt == 0) begin
      trace_len = used_len(len_setting);
      if (trace_len > longest_len) longest_len = trace_len;
    end
    half = trace_len / 2;
    trace_ring[ring_slot] = s;
    ring_slot = (ring_slot + 1) % MAX_WINDOW;
    prior = fill_cnt;
    fill_cnt = (prior + 1 >= trace_len) ? trace_len : prior + 1;

    // The trace ended before a full window: one flagged beat with a zero value.
    if (fill_cnt < trace_len) begin
      if (last) begin
        median_due.push_back('{value: '0, run_end: 1'b1, trace_end: 1'b1, short_trace: 1'b1});
        fill_cnt = 0;
        ring_slot = 0;
        traces_done++;
        short_traces++;
      end
      return;
    end

    // The first full window covers the leading edge; the last sample flushes the tail.
    n_res = (prior + 1 == trace_len) ? half + 1 : 1;
    if (last) n_res += trace_len - 1 - half;

    // Sort the newest window in signed order and take the element of rank half.
    for (i = 0; i < trace_len; i++) begin
      window[i] = trace_ring[(ring_slot + MAX_WINDOW - 1 - i) % MAX_WINDOW];
    end
    for (i = 1; i < trace_len; i++) begin
      key = window[i];
      j = i - 1;
      while (j >= 0 && $signed(window[j]) > $signed(key)) begin
        window[j + 1] = window[j];
        j--;
      end
      window[j + 1] = key;
    end
    for (i = 0; i < n_res; i++) begin
      median_due.push_back('{value: window[half], run_end: (i == n_res - 1),
                             trace_end: (i == n_res - 1) && last, short_trace: 1'b0});
    end
    if (last) begin
      fill_cnt = 0;
      ring_slot = 0;
      traces_done++;
    end
  endfunction

  // Offers one sample, with a random gap in front, and waits for its beat.
  task automatic send_beat(input sample_t s, input logic last);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= s;
    in_ch.last_sample <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_medians(s, last);
    samples_sent++;
  endtask

  // Stops offering, waits for every expected beat, then lets the block go quiet.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (median_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window_len(input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    len_setting = v;
  endtask

  task automatic check_field(input string what, input sample_t want, input sample_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what,
               $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  // Window length after reset is one, so every sample passes straight through.
  task automatic test_default_length();
    send_beat(32'h7FFF_FFFF, 1'b0);
    send_beat(32'h8000_0000, 1'b0);
    send_beat(32'h0000_0000, 1'b1);
    settle_block();
  endtask

  // Zero acts as one; odd and even lengths with the extreme values in the window.
  task automatic test_short_lengths();
    write_window_len(6'd0);
    send_beat(32'hFFFF_FFFF, 1'b0);
    send_beat(32'h0000_0001, 1'b1);
    settle_block();
    write_window_len(6'd3);
    send_beat(32'h7FFF_FFFF, 1'b0);
    send_beat(32'h8000_0000, 1'b0);
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'hFFFF_FFFF, 1'b1);
    settle_block();
    // An even length picks the upper of the two middle values.
    write_window_len(6'd2);
    send_beat(32'h0000_0005, 1'b0);
    send_beat(32'hFFFF_FFFB, 1'b0);
    send_beat(32'h0000_0007, 1'b1);
    settle_block();
  endtask

  // Traces that end before one window is full, including lengths that saturate.
  task automatic test_short_traces();
    write_window_len(6'd4);
    send_beat(32'h1234_5678, 1'b0);
    send_beat(32'hEDCB_A987, 1'b1);
    settle_block();
    write_window_len(6'd63);
    send_beat(32'h5555_5555, 1'b1);
    settle_block();
    write_window_len(6'd33);
    send_beat(32'hAAAA_AAAA, 1'b1);
    settle_block();
  endtask

  // A length written mid-trace applies only from the next trace on.
  task automatic test_mid_trace_change();
    write_window_len(6'd3);
    send_beat(32'h0000_0010, 1'b0);
    settle_block();
    write_window_len(6'd1);
    send_beat(32'h0000_0030, 1'b0);
    send_beat(32'h0000_0020, 1'b1);
    send_beat(32'h0000_0040, 1'b1);
    settle_block();
  endtask

  // The receiver holds off for a long stretch while samples keep coming.
  task automatic test_receiver_hold_off();
    int i;
    write_window_len(6'd1);
    hold_request = HOLD_CYCLES;
    for (i = 0; i < 10; i++) send_beat(noisy_sample(), i == 9);
    settle_block();
  endtask

  // Random traces with random lengths, under one setting of sender gaps and receiver stalls.
  task automatic test_random_traces(input int send_pct, input int recv_pct);
    int               sent, n_samples, eff, i;
    logic [CFG_W-1:0] len_cfg;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      case ($urandom_range(99, 0)) inside
        [0:64]:  len_cfg = CFG_W'($urandom_range(6, 1));
        [65:84]: len_cfg = CFG_W'($urandom_range(16, 7));
        [85:88]: len_cfg = CFG_W'($urandom_range(63, 0));
        [89:93]: len_cfg = '0;
        [94:96]: len_cfg = CFG_W'(MAX_WINDOW);
        default: len_cfg = '1;
      endcase
      write_window_len(len_cfg);
      eff = used_len(len_cfg);
      // Mostly full traces; some end early.
      if (eff > 1 && $urandom_range(99, 0) < 15) n_samples = $urandom_range(eff - 1, 1);
      else n_samples = eff + $urandom_range(6, 0);
      for (i = 0; i < n_samples; i++) send_beat(noisy_sample(), i == n_samples - 1);
      sent += n_samples;
      settle_block();
    end
  endtask

  // Receiver: random stalls, plus a counted hold-off on request.
  initial begin : receiver
    int stall_run;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_run = hold_request;
        hold_request = 0;
        out_ch.ready <= 1'b0;
        repeat (stall_run) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_checked++;
      if (median_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual value %0d", $time,
                 $signed(out_ch.median_value));
        mismatches++;
      end else begin
        due_beat = median_due.pop_front();
        check_field("median_value", due_beat.value, out_ch.median_value);
        check_field("run_end", sample_t'(due_beat.run_end), sample_t'(out_ch.run_end));
        check_field("trace_end", sample_t'(due_beat.trace_end), sample_t'(out_ch.trace_end));
        check_field("short_trace", sample_t'(due_beat.short_trace),
                    sample_t'(out_ch.short_trace));
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("sliding_median_despike_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.sample      <= '0;
    in_ch.last_sample <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_length();
    test_short_lengths();
    test_short_traces();
    test_mid_trace_change();
    test_receiver_hold_off();
    test_random_traces(0, 0);
    test_random_traces(80, 0);
    test_random_traces(0, 80);
    test_random_traces(10, 10);
    settle_block();

    if (median_due.size() != 0) begin
      $display("%0t: %0d expected result beats never arrived", $time, median_due.size());
      mismatches++;
    end
    $display("Sent %0d samples in %0d traces (%0d short), window lengths up to %0d.",
             samples_sent, traces_done, short_traces, longest_len);
    $display("Checked %0d median beats under stalls, gaps and a long hold-off; %0d errors.",
             beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("sliding_median_despike_test OK");
    end else begin
      $display("sliding_median_despike_test NOT OK");
    end
    $finish;
  end

endmodule
